[hw/rtl/kwt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the key watcher table.
// No dependencies; every other file depends on this package.

package kwt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int ACT_W    = 3;
    localparam int ID_W     = 64;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // raw command codes on the input word
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NOTIFY    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REM_OWNER = 3'd4;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_ADD,
        OP_REMOVE,
        OP_NOTIFY,
        OP_REM_OWNER,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DUP,
        ST_FULL,
        ST_MISSING
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_DONE
    } t_bk_state;

    typedef struct packed {
        logic [ID_W-1:0] watch_tbl;
        logic [ID_W-1:0] key_digest;
        logic [ID_W-1:0] owner_id;
    } t_entry;

    typedef struct packed {
        t_op    op;
        t_entry ent;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] match_count;
        logic [CNT_W-1:0] entry_count;
    } t_rsp;

endpackage

[hw/rtl/kwt_cmd_if.sv]
`timescale 1ns / 1ps
// Command channel: valid/ready handshake carrying one command word.
// Depends on kwt_pkg for field widths.

interface kwt_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [kwt_pkg::ACT_W-1:0]  action;
    logic [kwt_pkg::ID_W-1:0]   watch_tbl;
    logic [kwt_pkg::ID_W-1:0]   key_digest;
    logic [kwt_pkg::ID_W-1:0]   owner_id;

    modport source (output valid, output action, output watch_tbl, output key_digest,
                    output owner_id, input ready);
    modport sink   (input valid, input action, input watch_tbl, input key_digest,
                    input owner_id, output ready);
endinterface

[hw/rtl/kwt_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result word.
// Depends on kwt_pkg for field widths.

interface kwt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [kwt_pkg::CNT_W-1:0]  match_count;
    logic [kwt_pkg::CNT_W-1:0]  entry_count;

    modport source (output valid, output status, output match_count,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input match_count,
                    input entry_count, output ready);
endinterface

[hw/rtl/kwt_front.sv]
`timescale 1ns / 1ps
// Front end: accepts command words, decodes the action, queues them.
// Depends on kwt_pkg and kwt_cmd_if.

module kwt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    kwt_cmd_if.sink         i_cmd,
    input  logic            i_pop,
    output kwt_pkg::t_qhead o_head
);
    import kwt_pkg::*;

    t_cmd              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              push;
    t_cmd              dec;

    assign i_cmd.ready = (r_count != QCNT_W'(QDEPTH));
    assign push        = i_cmd.valid && i_cmd.ready;

    always_comb begin
        dec.ent.watch_tbl  = i_cmd.watch_tbl;
        dec.ent.key_digest = i_cmd.key_digest;
        dec.ent.owner_id   = i_cmd.owner_id;
        case (i_cmd.action)
            ACT_CLEAR:     dec.op = OP_CLEAR;
            ACT_ADD:       dec.op = OP_ADD;
            ACT_REMOVE:    dec.op = OP_REMOVE;
            ACT_NOTIFY:    dec.op = OP_NOTIFY;
            ACT_REM_OWNER: dec.op = OP_REM_OWNER;
            default:       dec.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

endmodule

[hw/rtl/kwt_back.sv]
`timescale 1ns / 1ps
// Back end: entry store, scan sequencer and result register.
// Depends on kwt_pkg and kwt_rsp_if.

module kwt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kwt_pkg::t_qhead i_head,
    output logic            o_pop,
    kwt_rsp_if.source       o_rsp
);
    import kwt_pkg::*;

    t_entry              r_mem [CAPACITY];
    t_entry              r_rd_data;
    logic [CAPACITY-1:0] r_valid,     n_valid;
    logic [CNT_W-1:0]    r_total,     n_total;
    logic [CNT_W-1:0]    r_matches,   n_matches;
    logic                r_dup,       n_dup;
    logic                r_have_free, n_have_free;
    logic [IDX_W-1:0]    r_free_idx,  n_free_idx;
    logic [IDX_W-1:0]    r_idx,       n_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_cmp_vld;
    t_cmd                r_cmd,       n_cmd;
    t_bk_state           r_state,     n_state;
    logic                r_out_vld,   n_out_vld;
    t_rsp                r_out,       n_out;
    logic                mem_we;
    logic                out_free;
    logic                slot_vld, eq_tk, eq_own;

    assign out_free = !r_out_vld || o_rsp.ready;
    assign slot_vld = r_valid[r_cmp_idx];
    assign eq_tk    = (r_rd_data.watch_tbl == r_cmd.ent.watch_tbl) &&
                      (r_rd_data.key_digest == r_cmd.ent.key_digest);
    assign eq_own   = (r_rd_data.owner_id == r_cmd.ent.owner_id);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_total     = r_total;
        n_matches   = r_matches;
        n_dup       = r_dup;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        o_pop       = 1'b0;
        mem_we      = 1'b0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        // compare stage, one entry behind the read address
        if (r_cmp_vld) begin
            case (r_cmd.op)
                OP_ADD: begin
                    if (slot_vld && eq_tk && eq_own) n_dup = 1'b1;
                    if (!slot_vld && !r_have_free) begin
                        n_have_free = 1'b1;
                        n_free_idx  = r_cmp_idx;
                    end
                end
                OP_REMOVE: begin
                    if (slot_vld && eq_tk && eq_own) begin
                        n_valid[r_cmp_idx] = 1'b0;
                        n_matches          = r_matches + 1'b1;
                        n_total            = r_total - 1'b1;
                    end
                end
                OP_NOTIFY: begin
                    if (slot_vld && eq_tk) n_matches = r_matches + 1'b1;
                end
                OP_REM_OWNER: begin
                    if (slot_vld && eq_own) begin
                        n_valid[r_cmp_idx] = 1'b0;
                        n_matches          = r_matches + 1'b1;
                        n_total            = r_total - 1'b1;
                    end
                end
                default: ;
            endcase
        end

        case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop       = 1'b1;
                    n_cmd       = i_head.cmd;
                    n_idx       = '0;
                    n_matches   = '0;
                    n_dup       = 1'b0;
                    n_have_free = 1'b0;
                    if (i_head.cmd.op inside {OP_ADD, OP_REMOVE, OP_NOTIFY, OP_REM_OWNER}) begin
                        n_state = BK_SCAN;
                    end else begin
                        n_state = BK_DONE;
                    end
                end
            end
            BK_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == IDX_W'(CAPACITY - 1)) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.status      = ST_OK;
                    n_out.match_count = r_matches;
                    n_out.entry_count = r_total;
                    case (r_cmd.op)
                        OP_CLEAR: begin
                            n_valid           = '0;
                            n_total           = '0;
                            n_out.match_count = '0;
                            n_out.entry_count = '0;
                        end
                        OP_ADD: begin
                            n_out.match_count = '0;
                            if (r_dup) begin
                                n_out.status = ST_DUP;
                            end else if (!r_have_free) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we              = 1'b1;
                                n_valid[r_free_idx] = 1'b1;
                                n_total             = r_total + 1'b1;
                                n_out.entry_count   = r_total + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_matches == '0) n_out.status = ST_MISSING;
                        end
                        OP_NOTIFY, OP_REM_OWNER: ;
                        default: begin
                            n_out.match_count = '0;
                        end
                    endcase
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_valid   <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_total   <= n_total;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= (r_state == BK_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_cmp_idx   <= r_idx;
        r_matches   <= n_matches;
        r_dup       <= n_dup;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        r_out       <= n_out;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_free_idx] <= r_cmd.ent;
        end
        r_rd_data <= r_mem[r_idx];
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.match_count = r_out.match_count;
    assign o_rsp.entry_count = r_out.entry_count;

endmodule

[hw/rtl/key_watcher_table.sv]
`timescale 1ns / 1ps
// Key watcher table, top level. A scanning command (add, remove, notify,
// remove-owner) walks every entry through the single read port in the back
// end after leaving the queue; clear and unused codes skip the scan. The back
// end takes the next command only after writing the result of the last one.
// Reset clears valid marks, entry count and queue; entry contents are not reset.

module key_watcher_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kwt_cmd_if.sink   i_cmd,
    kwt_rsp_if.source o_rsp
);
    import kwt_pkg::*;

    // head of the command queue and its pop strobe
    t_qhead head;
    logic   pop;

    // front end: takes a word whenever the two-deep queue has room, so the
    // source keeps moving while the back end is busy scanning
    kwt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_pop   (pop),
        .o_head  (head)
    );

    // back end: walks every entry per command, then writes one result word
    // into its output register; a pending result does not block the next scan
    kwt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
